### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Sizes, mode codes and the command and status bundles that the controller
// and the datapath exchange.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Map geometry.
	localparam int MAP_WORDS     = 128;
	localparam int WORD_BITS     = 32;
	localparam int TOTAL_ENTRIES = MAP_WORDS * WORD_BITS;
	localparam int ADDR_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int POS_W         = $clog2(WORD_BITS);

	// Field widths fixed by the interface.
	localparam int IDX_W = 12;
	localparam int RSV_W = 5;
	localparam int MODE_W = 2;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MARK    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	// Result status codes.
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the request and read its first word
		logic rd_next;   // read the next map word of a scan
		logic wr_en;     // write back the updated word if needed
		logic res_load;  // capture the result of the request
		logic out_set;   // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_alloc;
		logic found;
		logic last_word;
		logic out_busy;
	} stat_t;

endpackage

### rtl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator
// Top level: joins the request sequencer and the usage map datapath.
// ----------------------------------------------------------------------------
// The block keeps a usage bitmap of 128 words of 32 bits and serves one
// request at a time. A mark or release request reads the word that holds
// its entry, then writes it back updated if the entry lies in the map.
// An allocate request reads one map word per cycle from the single read port
// of the map memory, starting at word 0, until it finds a free entry or has
// searched the last word; it writes the word back only when it found one.
// The result waits in an output register; a new request is accepted once
// the previous one has moved its result there, so a stalled result side
// adds its stall cycles to the request that follows. The map reads as all
// free right after reset, so no clearing pass is needed.
module block_bitmap_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bba_pkg::MODE_W-1:0]    mode,
	input  logic [bba_pkg::IDX_W-1:0]     entry_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bba_pkg::IDX_W-1:0]     result_index,
	output logic                          status,
	input  logic                          cfg_we,
	input  logic [bba_pkg::RSV_W-1:0]     cfg_wdata
);

	bba_pkg::cmd_t  cmd;
	bba_pkg::stat_t st;

	// Request sequencer.
	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Map storage, search and result path.
	bba_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.mode         (mode),
		.entry_index  (entry_index),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_index (result_index),
		.status       (status)
	);

endmodule

### rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences one request at a time: capture, word scan or update, and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bba_pkg::stat_t st,
	output bba_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   finish;

	// A request ends when it is not an allocation, a free entry is found,
	// or the last word has been searched.
	assign finish   = !st.is_alloc || st.found || st.last_word;
	assign in_ready = (state_q == ST_IDLE);

	// Command decode.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_EVAL: begin
				cmd.wr_en    = finish;
				cmd.res_load = finish;
				cmd.rd_next  = !finish;
			end
			ST_DONE: begin
				cmd.out_set = !st.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (finish) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!st.out_busy) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// The map is written only while a request is being evaluated.
	a_wr_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> state_q == ST_EVAL)
		else $error("map write outside evaluation");

	// An accepted request blocks the input on the next cycle.
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still ready after accept");

	// A result is handed off only when the output register is free.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_set |-> !st.out_busy)
		else $error("result overwrote a pending output");
`endif

endmodule

### rtl/bba_datapath.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Usage map memory with per-word valid bits, first-free priority encoder,
// word update logic, reserved count register and output register.
// ----------------------------------------------------------------------------
module bba_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::cmd_t                 cmd,
	output bba_pkg::stat_t                st,
	input  logic [bba_pkg::MODE_W-1:0]    mode,
	input  logic [bba_pkg::IDX_W-1:0]     entry_index,
	input  logic                          cfg_we,
	input  logic [bba_pkg::RSV_W-1:0]     cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bba_pkg::IDX_W-1:0]     result_index,
	output logic                          status
);

	// Usage map and the valid bit of each word (an invalid word reads as free).
	bba_pkg::word_t mem [bba_pkg::MAP_WORDS];
	logic [bba_pkg::MAP_WORDS-1:0] wvalid_q;

	logic [bba_pkg::RSV_W-1:0]  rsv_q;
	logic [bba_pkg::MODE_W-1:0] mode_q;
	logic [bba_pkg::IDX_W-1:0]  idx_q;
	logic [bba_pkg::ADDR_W-1:0] scan_w_s1;
	bba_pkg::word_t             rdata_s1;
	logic                       rvalid_s1;
	logic [bba_pkg::IDX_W-1:0]  res_idx_q;
	logic                       res_st_q;
	logic                       out_valid_q;
	logic [bba_pkg::IDX_W-1:0]  out_idx_q;
	logic                       out_st_q;

	logic [bba_pkg::ADDR_W-1:0] rd_addr;
	logic                       rd_en;
	bba_pkg::word_t             cur_word;
	logic [31:0]                base;
	logic                       found;
	logic [bba_pkg::POS_W-1:0]  hit_p;
	logic [bba_pkg::POS_W-1:0]  ent_p;
	bba_pkg::word_t             ent_bit;
	bba_pkg::word_t             hit_bit;
	bba_pkg::word_t             wdata;
	logic                       in_range;
	logic                       wr_do;
	logic                       is_alloc;
	logic [31:0]                alloc_e;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_q <= '0;
		end else if (cfg_we) begin
			rsv_q <= cfg_wdata;
		end
	end

	// Read address: word 0 or the entry's word on a new request, else next word.
	always_comb begin
		rd_en = cmd.load || cmd.rd_next;
		if (cmd.load) begin
			if (mode == bba_pkg::MODE_ALLOC) begin
				rd_addr = '0;
			end else begin
				rd_addr = bba_pkg::ADDR_W'(entry_index / bba_pkg::WORD_BITS);
			end
		end else begin
			rd_addr = scan_w_s1 + bba_pkg::ADDR_W'(1);
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			idx_q  <= entry_index;
		end
	end

	// Map memory: one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1  <= mem[rd_addr];
			scan_w_s1 <= rd_addr;
		end
		if (wr_do) begin
			mem[scan_w_s1] <= wdata;
		end
	end

	// Word valid bits, cleared at reset so that the map starts free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q  <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (rd_en) rvalid_s1 <= wvalid_q[rd_addr];
			if (wr_do) wvalid_q[scan_w_s1] <= 1'b1;
		end
	end

	assign cur_word = rvalid_s1 ? rdata_s1 : '0;
	assign is_alloc = (mode_q == bba_pkg::MODE_ALLOC);
	assign base     = 32'(scan_w_s1) * bba_pkg::WORD_BITS;

	// First free entry of the word, counted from the most significant bit,
	// skipping entries below the reserved count.
	always_comb begin
		found = 1'b0;
		hit_p = '0;
		for (int p = bba_pkg::WORD_BITS - 1; p >= 0; p--) begin
			if (!cur_word[bba_pkg::WORD_BITS-1-p] && (base + 32'(p) >= 32'(rsv_q))) begin
				found = 1'b1;
				hit_p = bba_pkg::POS_W'(p);
			end
		end
	end

	// Word update for allocate, mark and release.
	assign ent_p    = bba_pkg::POS_W'(idx_q % bba_pkg::WORD_BITS);
	assign ent_bit  = bba_pkg::word_t'(1) << (bba_pkg::POS_W'(bba_pkg::WORD_BITS - 1) - ent_p);
	assign hit_bit  = bba_pkg::word_t'(1) << (bba_pkg::POS_W'(bba_pkg::WORD_BITS - 1) - hit_p);
	assign in_range = (32'(idx_q) < bba_pkg::TOTAL_ENTRIES);
	assign alloc_e  = base + 32'(hit_p);

	always_comb begin
		case (mode_q)
			bba_pkg::MODE_ALLOC:   wdata = cur_word | hit_bit;
			bba_pkg::MODE_MARK:    wdata = cur_word | ent_bit;
			bba_pkg::MODE_RELEASE: wdata = cur_word & ~ent_bit;
			default:               wdata = cur_word;
		endcase
	end

	assign wr_do = cmd.wr_en && (is_alloc ? found :
		(in_range && (mode_q == bba_pkg::MODE_MARK || mode_q == bba_pkg::MODE_RELEASE)));

	// Result capture.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (!is_alloc) begin
				res_idx_q <= idx_q;
				res_st_q  <= bba_pkg::STATUS_DONE;
			end else if (found) begin
				res_idx_q <= alloc_e[bba_pkg::IDX_W-1:0];
				res_st_q  <= bba_pkg::STATUS_DONE;
			end else begin
				res_idx_q <= '0;
				res_st_q  <= bba_pkg::STATUS_FULL;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_set) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_set) begin
			out_idx_q <= res_idx_q;
			out_st_q  <= res_st_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_index = out_idx_q;
	assign status       = out_st_q;

	// Status to the controller.
	assign st.is_alloc  = is_alloc;
	assign st.found     = found;
	assign st.last_word = (scan_w_s1 == bba_pkg::ADDR_W'(bba_pkg::MAP_WORDS - 1));
	assign st.out_busy  = out_valid_q && !out_ready;

`ifndef SYNTH
	// A result appears only after a hand-off from the controller.
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_set))
		else $error("output valid without a result hand-off");

	// A scan never reads past the last map word.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> !st.last_word)
		else $error("scan ran past the end of the map");

	// An allocation writes the map only when a free entry was found.
	a_alloc_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_do && is_alloc |-> found)
		else $error("allocation wrote without a free entry");
`endif

endmodule
